>>> rtl/lfdm_pkg.sv
// ----------------------------------------------------------------------------
// lfdm_pkg: shared types, constants and functions
// Field widths, register indexes, the steering pattern table, the duty
// reciprocal table and the per-wheel decode helpers.
// ----------------------------------------------------------------------------
package lfdm_pkg;

    localparam int PERIOD_W   = 16;
    localparam int SPEED_W    = 8;
    localparam int SENSOR_W   = 8;
    localparam int DIRECT_W   = 9;
    localparam int WHEEL_W    = 10;   // cruise (0..255) plus offset (-180..30)
    localparam int PCT_W      = 7;    // clamped magnitude 5..100
    localparam int RECIP_FRAC = 23;   // 2^23 > 100 * 65535 keeps the scaling exact
    localparam int RECIP_W    = 24;
    localparam int RECIP_N    = 2 ** PCT_W;

    localparam int S_DATA_W   = 40;   // 34 payload bits padded to whole bytes
    localparam int M_DATA_W   = 4 * PERIOD_W;
    localparam int M_USER_W   = 4;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = PERIOD_W;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PWM_PERIOD   = 1'b0,
        REG_CRUISE_SPEED = 1'b1
    } cfg_reg_t;

    localparam logic CMD_STEER  = 1'b0;
    localparam logic CMD_DIRECT = 1'b1;

    localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST   = 16'd2000;
    localparam logic [SPEED_W-1:0]  CRUISE_SPEED_RST = 8'd80;

    localparam int FULL_PCT = 100;
    localparam int MIN_PCT  = 5;

    // one step of the reciprocal table: 2^RECIP_FRAC split into quotient and
    // remainder by the full-scale percentage
    localparam longint RECIP_Q = (longint'(1) << RECIP_FRAC) / FULL_PCT;
    localparam longint RECIP_R = (longint'(1) << RECIP_FRAC) % FULL_PCT;

    // sensor patterns
    localparam logic [SENSOR_W-1:0] PAT_CENTER_REAR  = 8'he7;
    localparam logic [SENSOR_W-1:0] PAT_CENTER_FRONT = 8'h77;
    localparam logic [SENSOR_W-1:0] PAT_EF = 8'hef;
    localparam logic [SENSOR_W-1:0] PAT_F7 = 8'hf7;
    localparam logic [SENSOR_W-1:0] PAT_CF = 8'hcf;
    localparam logic [SENSOR_W-1:0] PAT_DF = 8'hdf;
    localparam logic [SENSOR_W-1:0] PAT_9F = 8'h9f;
    localparam logic [SENSOR_W-1:0] PAT_8F = 8'h8f;
    localparam logic [SENSOR_W-1:0] PAT_BF = 8'hbf;
    localparam logic [SENSOR_W-1:0] PAT_1F = 8'h1f;
    localparam logic [SENSOR_W-1:0] PAT_7F = 8'h7f;
    localparam logic [SENSOR_W-1:0] PAT_3F = 8'h3f;
    localparam logic [SENSOR_W-1:0] PAT_F3 = 8'hf3;
    localparam logic [SENSOR_W-1:0] PAT_FB = 8'hfb;
    localparam logic [SENSOR_W-1:0] PAT_F1 = 8'hf1;
    localparam logic [SENSOR_W-1:0] PAT_F9 = 8'hf9;
    localparam logic [SENSOR_W-1:0] PAT_F8 = 8'hf8;
    localparam logic [SENSOR_W-1:0] PAT_FD = 8'hfd;
    localparam logic [SENSOR_W-1:0] PAT_FE = 8'hfe;
    localparam logic [SENSOR_W-1:0] PAT_FC = 8'hfc;

    // steering offsets
    localparam logic signed [DIRECT_W-1:0] OFS_ZERO   = 9'sd0;
    localparam logic signed [DIRECT_W-1:0] OFS_UP30   = 9'sd30;
    localparam logic signed [DIRECT_W-1:0] OFS_DN60   = -9'sd60;
    localparam logic signed [DIRECT_W-1:0] OFS_DN80   = -9'sd80;
    localparam logic signed [DIRECT_W-1:0] OFS_DN130  = -9'sd130;
    localparam logic signed [DIRECT_W-1:0] OFS_DN150  = -9'sd150;
    localparam logic signed [DIRECT_W-1:0] OFS_DN180  = -9'sd180;

    typedef struct packed {
        logic [DIRECT_W-1:0] dl;
        logic [DIRECT_W-1:0] dr;
    } steer_ofs_t;

    typedef struct packed {
        logic [PCT_W-1:0] mag;
        logic             zero;
        logic             neg;
    } wheel_cmd_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] cval;
        logic                inv;
    } chan_out_t;

    typedef logic [RECIP_W-1:0] recip_tbl_t [0:RECIP_N-1];

    // ceil(m * 2^RECIP_FRAC / 100), so period * entry >> RECIP_FRAC is
    // floor(period * m / 100) for every 16-bit period; quotient and
    // remainder advance one step per entry
    function automatic recip_tbl_t build_recip();
        recip_tbl_t t;
        longint     q;
        longint     r;
        q = 0;
        r = 0;
        for (int i = 0; i < RECIP_N; i++) begin
            if (i <= FULL_PCT) begin
                t[i] = RECIP_W'(q + ((r != 0) ? longint'(1) : longint'(0)));
            end else begin
                t[i] = '0;
            end
            q = q + RECIP_Q;
            r = r + RECIP_R;
            if (r >= longint'(FULL_PCT)) begin
                q = q + 1;
                r = r - longint'(FULL_PCT);
            end
        end
        return t;
    endfunction

    localparam recip_tbl_t RECIP_TBL = build_recip();

    // first matching pattern wins
    function automatic steer_ofs_t steer_offsets(input logic [SENSOR_W-1:0] front,
                                                 input logic [SENSOR_W-1:0] rear);
        steer_ofs_t o;
        o.dl = OFS_ZERO;
        o.dr = OFS_ZERO;
        priority if (rear == PAT_CENTER_REAR && front == PAT_CENTER_FRONT) begin
            o.dl = OFS_ZERO;  o.dr = OFS_ZERO;
        end else if (rear == PAT_EF) begin
            o.dl = OFS_DN60;  o.dr = OFS_UP30;
        end else if (rear == PAT_F7) begin
            o.dl = OFS_UP30;  o.dr = OFS_DN60;
        end else if (rear == PAT_CF || rear == PAT_DF) begin
            o.dl = OFS_DN80;  o.dr = OFS_UP30;
        end else if (rear == PAT_9F || rear == PAT_8F) begin
            o.dl = OFS_DN130; o.dr = OFS_ZERO;
        end else if (rear == PAT_BF || rear == PAT_1F) begin
            o.dl = OFS_DN150; o.dr = OFS_ZERO;
        end else if (rear == PAT_7F || rear == PAT_3F) begin
            o.dl = OFS_DN180; o.dr = OFS_ZERO;
        end else if (rear == PAT_F3 || rear == PAT_FB) begin
            o.dl = OFS_UP30;  o.dr = OFS_DN80;
        end else if (rear == PAT_F1 || rear == PAT_F9) begin
            o.dl = OFS_ZERO;  o.dr = OFS_DN130;
        end else if (rear == PAT_F8 || rear == PAT_FD) begin
            o.dl = OFS_ZERO;  o.dr = OFS_DN150;
        end else if (rear == PAT_FE || rear == PAT_FC) begin
            o.dl = OFS_ZERO;  o.dr = OFS_DN180;
        end else begin
            o.dl = OFS_ZERO;  o.dr = OFS_ZERO;
        end
        return o;
    endfunction

    // magnitude clamped to 5..100 with saturation, plus sign and brake flags
    function automatic wheel_cmd_t wheel_decode(input logic [WHEEL_W-1:0] s);
        wheel_cmd_t          w;
        logic [WHEEL_W-1:0]  a;
        a      = s[WHEEL_W-1] ? (~s + WHEEL_W'(1)) : s;
        w.neg  = s[WHEEL_W-1];
        w.zero = (s == '0);
        if (a > WHEEL_W'(FULL_PCT)) begin
            w.mag = PCT_W'(FULL_PCT);
        end else if (a < WHEEL_W'(MIN_PCT)) begin
            w.mag = PCT_W'(MIN_PCT);
        end else begin
            w.mag = a[PCT_W-1:0];
        end
        return w;
    endfunction

    // a zero compare value flips to the inverting output at full period
    function automatic chan_out_t chan_out(input logic [PERIOD_W-1:0] cmp,
                                           input logic [PERIOD_W-1:0] period);
        chan_out_t c;
        c.inv  = (cmp == '0);
        c.cval = c.inv ? period : cmp;
        return c;
    endfunction

endpackage

>>> rtl/line_follow_dual_motor_pwm.sv
// ----------------------------------------------------------------------------
// line_follow_dual_motor_pwm: dual motor PWM compare generator
// Turns line-sensor patterns or a direct signed speed pair into forward and
// reverse compare values and invert flags for the left and right wheels.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Contents
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | one command: sensor bytes or a direct speed pair
//  m_axis   | out       | one result: four compare values, four invert flags
//  cfg      | in        | register writes: pwm_period, cruise_speed
//
//  One item per clock while m_axis accepts; each item is registered in the front
//  stage and then in the output stage. The output stage holds one 16x24 multiply
//  per wheel (period times a reciprocal table entry), which sets the clock period.
//  Reset clears both pipeline valids and restores pwm_period and cruise_speed.
//  A stalled m_axis holds its result; the front stage keeps accepting until
//  it too is full.
//
module line_follow_dual_motor_pwm (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // front_sensors[7:0], rear_sensors[15:8], direct_left[24:16],
    // direct_right[33:25], zero pad [39:34]
    input  logic [lfdm_pkg::S_DATA_W-1:0]       s_axis_tdata,
    // command[0]
    input  logic [0:0]                          s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // left_fwd_compare[15:0], left_rev_compare[31:16],
    // right_fwd_compare[47:32], right_rev_compare[63:48]
    output logic [lfdm_pkg::M_DATA_W-1:0]       m_axis_tdata,
    // left_fwd_invert[0], left_rev_invert[1], right_fwd_invert[2],
    // right_rev_invert[3]
    output logic [lfdm_pkg::M_USER_W-1:0]       m_axis_tuser,

    input  logic                                cfg_wr_en,
    input  logic [lfdm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [lfdm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import lfdm_pkg::*;

    // configuration
    logic [PERIOD_W-1:0]  period_reg;
    logic [SPEED_W-1:0]   cruise_reg;

    // front stage: decoded wheel commands
    logic                 st1_valid_reg;
    wheel_cmd_t           st1_left_reg,  st1_left_next;
    wheel_cmd_t           st1_right_reg, st1_right_next;

    // output stage
    logic                 m_valid_reg;
    logic [M_DATA_W-1:0]  m_data_reg, m_data_next;
    logic [M_USER_W-1:0]  m_user_reg, m_user_next;

    logic                 out_ready;
    logic                 s_xfer;

    // input unpacking
    logic [SENSOR_W-1:0]  front_sensors;
    logic [SENSOR_W-1:0]  rear_sensors;
    logic [DIRECT_W-1:0]  direct_left;
    logic [DIRECT_W-1:0]  direct_right;
    steer_ofs_t           ofs;
    logic [WHEEL_W-1:0]   cruise_ext;
    logic [WHEEL_W-1:0]   left_speed;
    logic [WHEEL_W-1:0]   right_speed;

    // output-stage arithmetic
    logic [PERIOD_W+RECIP_W-1:0] left_prod,  right_prod;
    logic [PERIOD_W-1:0]         left_duty,  right_duty;
    chan_out_t                   lf_out, lr_out, rf_out, rr_out;

    // advance the output stage when it is empty or its transfer completes;
    // the front stage moves whenever the output stage can take its item
    assign out_ready     = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !st1_valid_reg || out_ready;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // ---------------- front stage: steer, select, clamp ----------------
    assign front_sensors = s_axis_tdata[SENSOR_W-1:0];
    assign rear_sensors  = s_axis_tdata[2*SENSOR_W-1:SENSOR_W];
    assign direct_left   = s_axis_tdata[2*SENSOR_W+DIRECT_W-1:2*SENSOR_W];
    assign direct_right  = s_axis_tdata[2*SENSOR_W+2*DIRECT_W-1:2*SENSOR_W+DIRECT_W];

    assign ofs        = steer_offsets(front_sensors, rear_sensors);
    assign cruise_ext = {{(WHEEL_W-SPEED_W){1'b0}}, cruise_reg};

    always_comb begin
        if (s_axis_tuser[0] == CMD_DIRECT) begin
            // sign-extend the direct pair
            left_speed  = {{(WHEEL_W-DIRECT_W){direct_left[DIRECT_W-1]}},  direct_left};
            right_speed = {{(WHEEL_W-DIRECT_W){direct_right[DIRECT_W-1]}}, direct_right};
        end else begin
            // cruise speed plus the signed offset; 10 bits hold -180..285
            left_speed  = cruise_ext + {{(WHEEL_W-DIRECT_W){ofs.dl[DIRECT_W-1]}}, ofs.dl};
            right_speed = cruise_ext + {{(WHEEL_W-DIRECT_W){ofs.dr[DIRECT_W-1]}}, ofs.dr};
        end
        st1_left_next  = wheel_decode(left_speed);
        st1_right_next = wheel_decode(right_speed);
    end

    // ---------------- output stage: scale and map to channels ----------------
    // period * m / 100 via the reciprocal table, exact after the shift
    assign left_prod  = (PERIOD_W+RECIP_W)'(period_reg) *
                        (PERIOD_W+RECIP_W)'(RECIP_TBL[st1_left_reg.mag]);
    assign right_prod = (PERIOD_W+RECIP_W)'(period_reg) *
                        (PERIOD_W+RECIP_W)'(RECIP_TBL[st1_right_reg.mag]);

    always_comb begin
        // brake drives both channels at the full period
        left_duty  = st1_left_reg.zero  ? period_reg : left_prod[RECIP_FRAC +: PERIOD_W];
        right_duty = st1_right_reg.zero ? period_reg : right_prod[RECIP_FRAC +: PERIOD_W];

        // forward carries the duty unless reversing; reverse only when
        // reversing or braking
        lf_out = chan_out(st1_left_reg.neg ? '0 : left_duty, period_reg);
        lr_out = chan_out((st1_left_reg.neg || st1_left_reg.zero) ? left_duty : '0,
                          period_reg);
        rf_out = chan_out(st1_right_reg.neg ? '0 : right_duty, period_reg);
        rr_out = chan_out((st1_right_reg.neg || st1_right_reg.zero) ? right_duty : '0,
                          period_reg);

        m_data_next = {rr_out.cval, rf_out.cval, lr_out.cval, lf_out.cval};
        m_user_next = {rr_out.inv, rf_out.inv, lr_out.inv, lf_out.inv};
    end

    // ---------------- control and configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            period_reg    <= PWM_PERIOD_RST;
            cruise_reg    <= CRUISE_SPEED_RST;
        end else begin
            if (s_axis_tready) begin
                st1_valid_reg <= s_axis_tvalid;
            end
            if (out_ready) begin
                m_valid_reg <= st1_valid_reg;
            end
            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_PWM_PERIOD:   period_reg <= cfg_wdata[PERIOD_W-1:0];
                    REG_CRUISE_SPEED: cruise_reg <= cfg_wdata[SPEED_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            st1_left_reg  <= st1_left_next;
            st1_right_reg <= st1_right_next;
        end
        if (out_ready && st1_valid_reg) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for line_follow_dual_motor_pwm
// Drives sensor and direct speed commands through the s_axis stream, tracks
// every expected compare/invert result, and checks each m_axis transfer in
// order. Both stream sides idle at random, and the receiver also holds off
// for a long stretch. The period and cruise registers sweep through their
// extremes between phases.
// ----------------------------------------------------------------------------
module testbench;
    import lfdm_pkg::*;

    localparam int HALF_HIGH    = 6;
    localparam int HALF_LOW     = 6;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;
    localparam int IDLE_PCT     = 22;

    // one result transfer, split into its fields
    typedef struct packed {
        logic [PERIOD_W-1:0] left_fwd;
        logic [PERIOD_W-1:0] left_rev;
        logic [PERIOD_W-1:0] right_fwd;
        logic [PERIOD_W-1:0] right_rev;
        logic                left_fwd_inv;
        logic                left_rev_inv;
        logic                right_fwd_inv;
        logic                right_rev_inv;
    } pwm_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic [M_USER_W-1:0]   m_axis_tuser;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // bench copy of the two registers
    logic [PERIOD_W-1:0]   period_shadow;
    logic [SPEED_W-1:0]    cruise_shadow;

    pwm_result_t           expected_pwm_q[$];
    int                    mismatch_count;
    int                    cycle_count;
    int                    rx_hold_cycles;
    bit                    idle_on;

    // rear patterns that hit a steering rule, plus the center pattern
    logic [SENSOR_W-1:0]   rear_patterns[21];

    line_follow_dual_motor_pwm i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #HALF_LOW aclk = 1'b1;
        #HALF_HIGH aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // one wheel speed to its forward/reverse compare values and invert flags
    function automatic void wheel_to_channels(input int spd,
                                              output logic [PERIOD_W-1:0] fwd,
                                              output logic [PERIOD_W-1:0] rev,
                                              output logic fwd_inv,
                                              output logic rev_inv);
        int mag;
        int fwd_duty;
        int rev_duty;
        mag = (spd < 0) ? -spd : spd;
        // saturate, never wrap; a nonzero crawl is raised to the minimum
        if (mag > FULL_PCT) mag = FULL_PCT;
        if (mag < MIN_PCT) mag = MIN_PCT;
        if (spd == 0) begin
            // brake: both channels at the full period
            fwd_duty = int'(period_shadow);
            rev_duty = int'(period_shadow);
        end else if (spd > 0) begin
            fwd_duty = (int'(period_shadow) * mag) / FULL_PCT;
            rev_duty = 0;
        end else begin
            fwd_duty = 0;
            rev_duty = (int'(period_shadow) * mag) / FULL_PCT;
        end
        // a zero duty switches the channel to its inverting output
        fwd_inv = (fwd_duty == 0);
        rev_inv = (rev_duty == 0);
        fwd = fwd_inv ? period_shadow : PERIOD_W'(fwd_duty);
        rev = rev_inv ? period_shadow : PERIOD_W'(rev_duty);
    endfunction

    function automatic pwm_result_t predict_pwm(input logic cmd,
                                                input logic [SENSOR_W-1:0] front,
                                                input logic [SENSOR_W-1:0] rear,
                                                input logic [DIRECT_W-1:0] dl,
                                                input logic [DIRECT_W-1:0] dr);
        pwm_result_t res;
        int left_spd;
        int right_spd;
        int ofs_l;
        int ofs_r;
        ofs_l = 0;
        ofs_r = 0;
        if (cmd == CMD_STEER) begin
            // first matching rule wins; the center rule needs both bytes
            if (rear == PAT_CENTER_REAR && front == PAT_CENTER_FRONT) begin
                ofs_l = 0;
                ofs_r = 0;
            end else begin
                case (rear)
                    PAT_EF:         begin ofs_l = -60;  ofs_r = 30;   end
                    PAT_F7:         begin ofs_l = 30;   ofs_r = -60;  end
                    PAT_CF, PAT_DF: begin ofs_l = -80;  ofs_r = 30;   end
                    PAT_9F, PAT_8F: begin ofs_l = -130; ofs_r = 0;    end
                    PAT_BF, PAT_1F: begin ofs_l = -150; ofs_r = 0;    end
                    PAT_7F, PAT_3F: begin ofs_l = -180; ofs_r = 0;    end
                    PAT_F3, PAT_FB: begin ofs_l = 30;   ofs_r = -80;  end
                    PAT_F1, PAT_F9: begin ofs_l = 0;    ofs_r = -130; end
                    PAT_F8, PAT_FD: begin ofs_l = 0;    ofs_r = -150; end
                    PAT_FE, PAT_FC: begin ofs_l = 0;    ofs_r = -180; end
                    default:        begin ofs_l = 0;    ofs_r = 0;    end
                endcase
            end
            left_spd  = int'(cruise_shadow) + ofs_l;
            right_spd = int'(cruise_shadow) + ofs_r;
        end else begin
            left_spd  = int'($signed(dl));
            right_spd = int'($signed(dr));
        end
        wheel_to_channels(left_spd, res.left_fwd, res.left_rev,
                          res.left_fwd_inv, res.left_rev_inv);
        wheel_to_channels(right_spd, res.right_fwd, res.right_rev,
                          res.right_fwd_inv, res.right_rev_inv);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string fname, input logic [PERIOD_W-1:0] exp_v,
                               input logic [PERIOD_W-1:0] act_v, inout bit bad);
        if (exp_v !== act_v) begin
            bad = 1'b1;
            if (mismatch_count < REPORT_MAX) begin
                $display("mismatch at cycle %0d: %s expected %0d, got %0d",
                         cycle_count, fname, exp_v, act_v);
            end
        end
    endtask

    // compare every m_axis transfer against the oldest expectation
    always @(posedge aclk) begin
        pwm_result_t exp_r;
        bit          bad;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            bad = 1'b0;
            if (expected_pwm_q.size() == 0) begin
                if (mismatch_count < REPORT_MAX) begin
                    $display("unexpected result transfer at cycle %0d: tdata %h tuser %h",
                             cycle_count, m_axis_tdata, m_axis_tuser);
                end
                mismatch_count++;
            end else begin
                exp_r = expected_pwm_q.pop_front();
                check_field("left_fwd_compare", exp_r.left_fwd, m_axis_tdata[15:0], bad);
                check_field("left_rev_compare", exp_r.left_rev, m_axis_tdata[31:16], bad);
                check_field("right_fwd_compare", exp_r.right_fwd, m_axis_tdata[47:32], bad);
                check_field("right_rev_compare", exp_r.right_rev, m_axis_tdata[63:48], bad);
                check_field("left_fwd_invert", PERIOD_W'(exp_r.left_fwd_inv),
                            PERIOD_W'(m_axis_tuser[0]), bad);
                check_field("left_rev_invert", PERIOD_W'(exp_r.left_rev_inv),
                            PERIOD_W'(m_axis_tuser[1]), bad);
                check_field("right_fwd_invert", PERIOD_W'(exp_r.right_fwd_inv),
                            PERIOD_W'(m_axis_tuser[2]), bad);
                check_field("right_rev_invert", PERIOD_W'(exp_r.right_rev_inv),
                            PERIOD_W'(m_axis_tuser[3]), bad);
                if (bad) mismatch_count++;
            end
        end
    end

    // bound the run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("line_follow_dual_motor_pwm verification failed");
            $finish;
        end
    end

    // receiver: long hold-off on request, otherwise random stalls
    always @(negedge aclk) begin
        if (rx_hold_cycles > 0) begin
            m_axis_tready = 1'b0;
            rx_hold_cycles = rx_hold_cycles - 1;
        end else begin
            m_axis_tready = !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // offer one command, record its expectation on the accepting edge
    task automatic send_cmd(input logic cmd, input logic [SENSOR_W-1:0] front,
                            input logic [SENSOR_W-1:0] rear,
                            input logic [DIRECT_W-1:0] dl,
                            input logic [DIRECT_W-1:0] dr);
        bit accepted;
        accepted = 1'b0;
        if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_axis_tdata  = S_DATA_W'({dr, dl, rear, front});
        s_axis_tuser  = cmd;
        s_axis_tvalid = 1'b1;
        while (!accepted) begin
            @(posedge aclk);
            if (s_axis_tready) begin
                accepted = 1'b1;
                expected_pwm_q.push_back(predict_pwm(cmd, front, rear, dl, dr));
            end
        end
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    // hold the sender until every result is back, then let the pipe settle
    task automatic wait_drained();
        while (expected_pwm_q.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (idx == REG_PWM_PERIOD) period_shadow = val;
        else cruise_shadow = val[SPEED_W-1:0];
    endtask

    // direct speed biased toward the clamp edges, brake and full-scale values
    function automatic logic [DIRECT_W-1:0] pick_speed();
        int v;
        case ($urandom_range(3))
            0: v = $urandom_range(511);
            1: v = $urandom_range(12) - 6;
            2: v = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(95, 105));
            default: v = $urandom_range(1) ? 255 : -256;
        endcase
        return DIRECT_W'(v);
    endfunction

    // steering commands mostly use table patterns with random spare fields, the rest raw noise
    task automatic send_random_cmd();
        logic                cmd;
        logic [SENSOR_W-1:0] front;
        logic [SENSOR_W-1:0] rear;
        cmd   = 1'($urandom_range(1));
        front = SENSOR_W'($urandom_range(255));
        rear  = SENSOR_W'($urandom_range(255));
        if (cmd == CMD_STEER && $urandom_range(99) < 65) begin
            rear = rear_patterns[$urandom_range(20)];
            if (rear == PAT_CENTER_REAR && $urandom_range(1)) front = PAT_CENTER_FRONT;
        end
        send_cmd(cmd, front, rear, pick_speed(), pick_speed());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // every steering rule and the direct speed extremes at reset settings
    task automatic test_directed();
        send_cmd(CMD_STEER, PAT_CENTER_FRONT, PAT_CENTER_REAR, 9'h000, 9'h1ff);
        send_cmd(CMD_STEER, 8'h00, PAT_CENTER_REAR, 9'h100, 9'h0ff);
        send_cmd(CMD_STEER, 8'hff, PAT_EF, 9'h1ff, 9'h1ff);
        send_cmd(CMD_STEER, 8'h00, PAT_F7, 9'h000, 9'h000);
        send_cmd(CMD_STEER, 8'h55, PAT_CF, 9'h0aa, 9'h155);
        send_cmd(CMD_STEER, 8'haa, PAT_9F, 9'h155, 9'h0aa);
        send_cmd(CMD_STEER, 8'h77, PAT_BF, 9'h000, 9'h000);
        send_cmd(CMD_STEER, 8'h77, PAT_7F, 9'h000, 9'h000);
        send_cmd(CMD_STEER, 8'h77, PAT_F3, 9'h000, 9'h000);
        send_cmd(CMD_STEER, 8'h77, PAT_F1, 9'h000, 9'h000);
        send_cmd(CMD_STEER, 8'h77, PAT_F8, 9'h000, 9'h000);
        send_cmd(CMD_STEER, 8'h77, PAT_FE, 9'h000, 9'h000);
        send_cmd(CMD_STEER, 8'hff, 8'h00, 9'h000, 9'h000);
        // direct: brake, saturation, minimum raise, signed extremes
        send_cmd(CMD_DIRECT, 8'hff, 8'hff, 9'h000, 9'h000);
        send_cmd(CMD_DIRECT, 8'h00, 8'h00, 9'h0ff, DIRECT_W'(-256));
        send_cmd(CMD_DIRECT, PAT_CENTER_FRONT, PAT_CENTER_REAR, 9'h001, DIRECT_W'(-1));
        send_cmd(CMD_DIRECT, 8'h00, PAT_EF, 9'h004, 9'h005);
        send_cmd(CMD_DIRECT, 8'h00, 8'h00, DIRECT_W'(100), DIRECT_W'(101));
        send_cmd(CMD_DIRECT, 8'h00, 8'h00, DIRECT_W'(-100), DIRECT_W'(-101));
        send_cmd(CMD_DIRECT, 8'h00, 8'h00, DIRECT_W'(-5), DIRECT_W'(-4));
    endtask

    // fill the block against a stalled receiver, then drain fully
    task automatic test_backpressure();
        rx_hold_cycles = 300;
        repeat (60) send_random_cmd();
        wait_drained();
    endtask

    // random traffic with a long stretch free of random idles in the middle
    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++) begin
            idle_on = !(i >= count / 3 && i < count / 3 + 250);
            send_random_cmd();
        end
        idle_on = 1'b1;
        wait_drained();
    endtask

    // walk the registers through their extremes between idle phases
    task automatic test_register_sweep();
        logic [CFG_DATA_W-1:0] periods[8];
        logic [CFG_DATA_W-1:0] cruises[8];
        periods = '{16'd1, 16'd0, 16'hffff, 16'd99, 16'd19, 16'd0, 16'hffff, 16'd2000};
        cruises = '{16'd80, 16'd200, 16'd255, 16'd0, 16'd5, 16'hff00, 16'h00ff, 16'd80};
        // one setting with garbage in the unused cruise bits
        periods[5] = CFG_DATA_W'($urandom_range(65535));
        cruises[5] = CFG_DATA_W'($urandom_range(65535));
        for (int k = 0; k < 8; k++) begin
            wait_drained();
            write_reg(REG_PWM_PERIOD, periods[k]);
            write_reg(REG_CRUISE_SPEED, cruises[k]);
            repeat (55) send_random_cmd();
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = CMD_STEER;
        m_axis_tready  = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = REG_PWM_PERIOD;
        cfg_wdata      = '0;
        period_shadow  = PWM_PERIOD_RST;
        cruise_shadow  = CRUISE_SPEED_RST;
        mismatch_count = 0;
        cycle_count    = 0;
        rx_hold_cycles = 0;
        idle_on        = 1'b1;
        rear_patterns  = '{PAT_CENTER_REAR, PAT_EF, PAT_F7, PAT_CF, PAT_DF, PAT_9F, PAT_8F,
                           PAT_BF, PAT_1F, PAT_7F, PAT_3F, PAT_F3, PAT_FB, PAT_F1,
                           PAT_F9, PAT_F8, PAT_FD, PAT_FE, PAT_FC, PAT_CENTER_REAR,
                           PAT_CENTER_FRONT};

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed();
        test_backpressure();
        test_register_sweep();
        test_random_traffic(1450);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("line_follow_dual_motor_pwm verification clean");
        end else begin
            $display("line_follow_dual_motor_pwm verification failed");
        end
        $finish;
    end

endmodule
